[hw/rtl/glyph_address_lookup_core_defines.svh]
// ----------------------------------------------------------------------------
// Glyph address lookup assertion macros
// Concurrent assertion forms used by the lookup controller module.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ADDRESS_LOOKUP_CORE_DEFINES_SVH
`define GLYPH_ADDRESS_LOOKUP_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define GAL_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/gal_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph address lookup package
// Sizes, codes and transaction types shared by the lookup core modules.
// ----------------------------------------------------------------------------
package gal_pkg;

   localparam int GLYPH_ENTRIES = 4096;
   localparam int GIDX_W        = $clog2(GLYPH_ENTRIES);

   localparam int DIR_DEPTH = 256;
   localparam int DIR_AW    = $clog2(DIR_DEPTH);
   localparam int BKT_DEPTH = 256;
   localparam int BKT_AW    = $clog2(BKT_DEPTH);

   localparam int CODE_W    = 16;
   localparam int OFFSET_W  = 32;
   localparam int DIR_WIDTH = 16;
   localparam int INDEX_W   = 12;
   localparam int FIRST_W   = 12;
   localparam int COUNT_W   = 13;
   localparam int SRCH_W    = $clog2((1 << FIRST_W) + (1 << COUNT_W));

   localparam logic [DIR_WIDTH-1:0] DIRECT_MISSING = 16'hffff;
   localparam logic [7:0]           DIRECT_LAST    = 8'hff;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKUP_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BASE   = 1'b1;

   typedef enum logic [1:0] {
      ACT_LOOKUP    = 2'd0,
      ACT_WR_DIRECT = 2'd1,
      ACT_WR_BUCKET = 2'd2,
      ACT_WR_GLYPH  = 2'd3
   } gal_action_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIRECT = 2'd1,
      ST_BUCKET = 2'd2,
      ST_GLYPH  = 2'd3
   } gal_state_type;

   typedef struct packed {
      gal_action_type        action;
      logic [CODE_W-1:0]     char_code;
      logic [INDEX_W-1:0]    table_index;
      logic [OFFSET_W-1:0]   entry_offset;
      logic [FIRST_W-1:0]    bucket_first;
      logic [COUNT_W-1:0]    bucket_count;
   } gal_req_type;

   typedef struct packed {
      logic                  found;
      logic [OFFSET_W-1:0]   glyph_address;
   } gal_rsp_type;

   typedef struct packed {
      logic                  lookup_mode;
      logic [OFFSET_W-1:0]   data_base;
   } gal_cfg_type;

   typedef struct packed {
      logic [FIRST_W-1:0]    first;
      logic [COUNT_W-1:0]    count;
   } gal_bucket_type;

   typedef struct packed {
      logic [CODE_W-1:0]     code;
      logic [OFFSET_W-1:0]   offset;
   } gal_glyph_type;

   localparam int BKT_WIDTH = $bits(gal_bucket_type);
   localparam int GLY_WIDTH = $bits(gal_glyph_type);

   typedef struct packed {
      logic                  dir_we;
      logic [DIR_AW-1:0]     dir_waddr;
      logic [DIR_WIDTH-1:0]  dir_wdata;
      logic [DIR_AW-1:0]     dir_raddr;
      logic                  bkt_we;
      logic [BKT_AW-1:0]     bkt_waddr;
      gal_bucket_type        bkt_wdata;
      logic [BKT_AW-1:0]     bkt_raddr;
      logic                  gly_we;
      logic [GIDX_W-1:0]     gly_waddr;
      gal_glyph_type         gly_wdata;
      logic [GIDX_W-1:0]     gly_raddr;
   } gal_mem_cmd_type;

endpackage

[hw/rtl/gal_ram.sv]
// ----------------------------------------------------------------------------
// Glyph address lookup RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gal_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gal_ctrl.sv]
// ----------------------------------------------------------------------------
// Glyph address lookup controller
// Decodes transactions, drives the table memories and walks bucket entries.
// ----------------------------------------------------------------------------
`include "glyph_address_lookup_core_defines.svh"

module gal_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gal_pkg::gal_req_type            req,
   input  gal_pkg::gal_cfg_type            cfg,
   output gal_pkg::gal_mem_cmd_type        mem_cmd,
   input  logic [gal_pkg::DIR_WIDTH-1:0]   dir_rdata,
   input  logic [gal_pkg::BKT_WIDTH-1:0]   bkt_rdata,
   input  logic [gal_pkg::GLY_WIDTH-1:0]   gly_rdata,
   output logic                            rsp_strobe,
   output gal_pkg::gal_rsp_type            rsp
);
   import gal_pkg::*;

   gal_state_type        state_ff, state_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [SRCH_W-1:0]    srch_idx_ff, srch_idx_in;
   logic [COUNT_W-1:0]   remain_ff, remain_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   gal_rsp_type          rsp_ff, rsp_in;

   logic                 accept;
   logic                 lookup_accept;
   gal_bucket_type       bkt_entry;
   gal_glyph_type        gly_entry;
   logic                 past_end;
   logic                 zero_entry;
   logic                 code_match;
   logic                 glyph_done;
   logic                 glyph_hit;
   logic                 res_found;
   logic [OFFSET_W-1:0]  res_offset;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign lookup_accept = accept && (req.action == ACT_LOOKUP);

   assign bkt_entry = gal_bucket_type'(bkt_rdata);
   assign gly_entry = gal_glyph_type'(gly_rdata);

   assign past_end   = 32'(srch_idx_ff) >= 32'(GLYPH_ENTRIES);
   assign zero_entry = (gly_entry.code == '0) && (gly_entry.offset == '0);
   assign code_match = (gly_entry.code == code_ff);
   assign glyph_done = past_end || zero_entry || code_match || (remain_ff == COUNT_W'(1));
   assign glyph_hit  = !past_end && !zero_entry && code_match;

   always_comb begin
      mem_cmd           = '0;
      mem_cmd.dir_we    = accept && (req.action == ACT_WR_DIRECT) &&
                          (32'(req.table_index) < 32'(DIR_DEPTH));
      mem_cmd.dir_waddr = DIR_AW'(req.table_index);
      mem_cmd.dir_wdata = req.entry_offset[DIR_WIDTH-1:0];
      mem_cmd.dir_raddr = req.char_code[DIR_AW-1:0];
      mem_cmd.bkt_we    = accept && (req.action == ACT_WR_BUCKET) &&
                          (32'(req.table_index) < 32'(BKT_DEPTH));
      mem_cmd.bkt_waddr = BKT_AW'(req.table_index);
      mem_cmd.bkt_wdata.first = req.bucket_first;
      mem_cmd.bkt_wdata.count = req.bucket_count;
      mem_cmd.bkt_raddr = req.char_code[CODE_W-1 -: BKT_AW];
      mem_cmd.gly_we    = accept && (req.action == ACT_WR_GLYPH) &&
                          (32'(req.table_index) < 32'(GLYPH_ENTRIES));
      mem_cmd.gly_waddr = GIDX_W'(req.table_index);
      mem_cmd.gly_wdata.code   = req.char_code;
      mem_cmd.gly_wdata.offset = req.entry_offset;
      if (state_ff == ST_BUCKET) begin
         mem_cmd.gly_raddr = GIDX_W'(bkt_entry.first);
      end else begin
         mem_cmd.gly_raddr = GIDX_W'(srch_idx_ff + SRCH_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (lookup_accept) begin
               state_in = cfg.lookup_mode ? ST_BUCKET : ST_DIRECT;
            end
         end
         ST_DIRECT: begin
            state_in = ST_IDLE;
         end
         ST_BUCKET: begin
            state_in = (bkt_entry.count == '0) ? ST_IDLE : ST_GLYPH;
         end
         ST_GLYPH: begin
            if (glyph_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      code_in     = lookup_accept ? req.char_code : code_ff;
      srch_idx_in = srch_idx_ff;
      remain_in   = remain_ff;
      case (state_ff)
         ST_BUCKET: begin
            srch_idx_in = SRCH_W'(bkt_entry.first);
            remain_in   = bkt_entry.count;
         end
         ST_GLYPH: begin
            srch_idx_in = srch_idx_ff + SRCH_W'(1);
            remain_in   = remain_ff - COUNT_W'(1);
         end
         default: begin
            srch_idx_in = srch_idx_ff;
            remain_in   = remain_ff;
         end
      endcase
   end

   always_comb begin
      rsp_strobe_in = 1'b0;
      res_found     = 1'b0;
      res_offset    = '0;
      case (state_ff)
         ST_DIRECT: begin
            rsp_strobe_in = 1'b1;
            res_found     = (code_ff <= CODE_W'(DIRECT_LAST)) && (dir_rdata != DIRECT_MISSING);
            res_offset    = OFFSET_W'(dir_rdata);
         end
         ST_BUCKET: begin
            rsp_strobe_in = (bkt_entry.count == '0);
         end
         ST_GLYPH: begin
            rsp_strobe_in = glyph_done;
            res_found     = glyph_hit;
            res_offset    = gly_entry.offset;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
      rsp_in.found         = res_found;
      rsp_in.glyph_address = res_found ? (cfg.data_base + res_offset) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      srch_idx_ff <= srch_idx_in;
      remain_ff   <= remain_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `GAL_ASSERT_HOLDS(a_rsp_in_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE, "result outside idle")
   `GAL_ASSERT_NEXT(a_write_no_rsp, clock, reset, accept && !lookup_accept, !rsp_strobe_ff, "write gave a result")
   `GAL_ASSERT_NEXT(a_lookup_busy, clock, reset, lookup_accept, state_ff != ST_IDLE, "lookup not started")
   `GAL_ASSERT_HOLDS(a_search_count, clock, reset, state_ff == ST_GLYPH, remain_ff != '0, "empty search step")

endmodule

[hw/rtl/glyph_address_lookup_core.sv]
// ----------------------------------------------------------------------------
// Glyph address lookup core
// Maps a character code to its bitmap address through direct or bucketed
// font tables held in on-chip memories.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A lookup
// transaction gives exactly one result; a table write gives none.
// Table writes complete in the accepting cycle and leave busy low.
// A direct lookup reads the direct table in the direct state; the result
// is registered and shown on rsp_strobe and rsp_data once the core is idle,
// and the next transaction can be taken in that cycle.
// A bucketed lookup reads the bucket entry, then walks the glyph memory
// one entry per cycle. An empty bucket answers from the bucket state.
// The result is valid for exactly one cycle; the receiver cannot stall it.
// Configuration registers are written through csr_we, csr_index and
// csr_wdata only while the core is idle; the user must keep to this, as
// the core does not enforce it. Reset clears both registers and the
// controller state; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module glyph_address_lookup_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gal_pkg::gal_req_type            req_data,
   output logic                            rsp_strobe,
   output gal_pkg::gal_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [gal_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gal_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gal_pkg::*;

   logic                 lookup_mode_ff, lookup_mode_in;
   logic [OFFSET_W-1:0]  data_base_ff, data_base_in;
   gal_cfg_type          cfg;
   gal_mem_cmd_type      mem_cmd;
   logic [DIR_WIDTH-1:0] dir_rdata;
   logic [BKT_WIDTH-1:0] bkt_rdata;
   logic [GLY_WIDTH-1:0] gly_rdata;

   always_comb begin
      lookup_mode_in = lookup_mode_ff;
      data_base_in   = data_base_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOOKUP_MODE: lookup_mode_in = csr_wdata[0];
            CSR_DATA_BASE:   data_base_in   = OFFSET_W'(csr_wdata);
            default: begin
               lookup_mode_in = lookup_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_mode_ff <= 1'b0;
         data_base_ff   <= '0;
      end else begin
         lookup_mode_ff <= lookup_mode_in;
         data_base_ff   <= data_base_in;
      end
   end

   assign cfg.lookup_mode = lookup_mode_ff;
   assign cfg.data_base   = data_base_ff;

   gal_ram #(
      .WIDTH (DIR_WIDTH),
      .DEPTH (DIR_DEPTH)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.dir_we),
      .wr_addr (mem_cmd.dir_waddr),
      .wr_data (mem_cmd.dir_wdata),
      .rd_addr (mem_cmd.dir_raddr),
      .rd_data (dir_rdata)
   );

   gal_ram #(
      .WIDTH (BKT_WIDTH),
      .DEPTH (BKT_DEPTH)
   ) u_bkt_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.bkt_we),
      .wr_addr (mem_cmd.bkt_waddr),
      .wr_data (mem_cmd.bkt_wdata),
      .rd_addr (mem_cmd.bkt_raddr),
      .rd_data (bkt_rdata)
   );

   gal_ram #(
      .WIDTH (GLY_WIDTH),
      .DEPTH (GLYPH_ENTRIES)
   ) u_gly_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.gly_we),
      .wr_addr (mem_cmd.gly_waddr),
      .wr_data (mem_cmd.gly_wdata),
      .rd_addr (mem_cmd.gly_raddr),
      .rd_data (gly_rdata)
   );

   gal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_data),
      .cfg        (cfg),
      .mem_cmd    (mem_cmd),
      .dir_rdata  (dir_rdata),
      .bkt_rdata  (bkt_rdata),
      .gly_rdata  (gly_rdata),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

[tb/sv/tb_glyph_address_lookup_core.sv]
// ----------------------------------------------------------------------------
// Glyph address lookup core testbench
// Drives table loads and character lookups into the core in both lookup
// modes under several data base settings. Every lookup result is predicted
// from a local copy of the font tables and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_glyph_address_lookup_core;

   import gal_pkg::*;

   localparam logic LOOKUP_DIRECT   = 1'b0;
   localparam logic LOOKUP_BUCKETED = 1'b1;
   localparam int   WATCHDOG_LIMIT  = 50000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   gal_req_type           req_data;
   logic                  rsp_strobe;
   gal_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Local copy of the font stores and registers.
   logic [DIR_WIDTH-1:0] dir_tab [DIR_DEPTH];
   gal_bucket_type       bkt_tab [BKT_DEPTH];
   gal_glyph_type        gly_tab [GLYPH_ENTRIES];
   bit                   dir_ok  [DIR_DEPTH];
   bit                   bkt_ok  [BKT_DEPTH];
   bit                   gly_ok  [GLYPH_ENTRIES];
   gal_cfg_type          cfg_q;

   gal_rsp_type          pending_lookups [$];
   logic [CODE_W-1:0]    known_codes [$];

   int mismatches;
   int n_lookups;
   int n_hits;
   int n_writes;
   int n_settings;
   int burst_left;
   int stall_cycles;

   glyph_address_lookup_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Returns 0 when the lookup would read a table entry that was never written.
   function automatic bit resolve_glyph(input logic [CODE_W-1:0] code,
                                        output gal_rsp_type rsp);
      gal_bucket_type bkt;
      int unsigned    gidx;
      int unsigned    step;
      bit             defined;
      bit             done;
      rsp = '0;
      defined = 1'b1;
      if (cfg_q.lookup_mode == LOOKUP_DIRECT) begin
         if (code <= DIRECT_LAST) begin
            defined = dir_ok[code[7:0]];
            if (defined && dir_tab[code[7:0]] != DIRECT_MISSING) begin
               rsp.found = 1'b1;
               rsp.glyph_address = cfg_q.data_base + dir_tab[code[7:0]];
            end
         end
      end else begin
         defined = bkt_ok[code[15:8]];
         bkt = bkt_tab[code[15:8]];
         done = !defined;
         step = 0;
         while (!done && step < bkt.count) begin
            gidx = bkt.first + step;
            if (gidx >= GLYPH_ENTRIES) begin
               done = 1'b1;
            end else if (!gly_ok[gidx]) begin
               defined = 1'b0;
               done = 1'b1;
            end else if (gly_tab[gidx] == '0) begin
               done = 1'b1;
            end else if (gly_tab[gidx].code == code) begin
               rsp.found = 1'b1;
               rsp.glyph_address = cfg_q.data_base + gly_tab[gidx].offset;
               done = 1'b1;
            end
            step++;
         end
      end
      return defined;
   endfunction

   function automatic void absorb_transaction(input gal_req_type item);
      gal_rsp_type rsp;
      case (item.action)
         ACT_LOOKUP: begin
            void'(resolve_glyph(item.char_code, rsp));
            pending_lookups.push_back(rsp);
            n_lookups++;
            if (rsp.found) n_hits++;
         end
         ACT_WR_DIRECT: begin
            n_writes++;
            if (item.table_index < DIR_DEPTH) begin
               dir_tab[item.table_index[7:0]] = item.entry_offset[15:0];
               dir_ok[item.table_index[7:0]] = 1'b1;
            end
         end
         ACT_WR_BUCKET: begin
            n_writes++;
            if (item.table_index < BKT_DEPTH) begin
               bkt_tab[item.table_index[7:0]].first = item.bucket_first;
               bkt_tab[item.table_index[7:0]].count = item.bucket_count;
               bkt_ok[item.table_index[7:0]] = 1'b1;
            end
         end
         default: begin
            n_writes++;
            if (item.table_index < GLYPH_ENTRIES) begin
               gly_tab[item.table_index].code = item.char_code;
               gly_tab[item.table_index].offset = item.entry_offset;
               gly_ok[item.table_index] = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic int next_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 50);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic gal_req_type noise_item();
      gal_req_type item;
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      r0 = $urandom;
      r1 = $urandom;
      r2 = $urandom;
      item.action = gal_action_type'(r0[1:0]);
      item.char_code = r0[17:2];
      item.table_index = r0[29:18];
      item.entry_offset = r1;
      item.bucket_first = r2[11:0];
      item.bucket_count = r2[24:12];
      return item;
   endfunction

   function automatic logic [31:0] direct_offset();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 5) == 0) r[15:0] = DIRECT_MISSING;
      return r;
   endfunction

   task automatic send_item(input gal_req_type item);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      absorb_transaction(item);
   endtask

   task automatic send_lookup(input logic [CODE_W-1:0] code, output bit sent);
      gal_req_type item;
      gal_rsp_type probe;
      sent = resolve_glyph(code, probe);
      if (sent) begin
         item = noise_item();
         item.action = ACT_LOOKUP;
         item.char_code = code;
         send_item(item);
      end
   endtask

   task automatic write_direct(input logic [INDEX_W-1:0] index,
                               input logic [OFFSET_W-1:0] offset);
      gal_req_type item;
      item = noise_item();
      item.action = ACT_WR_DIRECT;
      item.table_index = index;
      item.entry_offset = offset;
      send_item(item);
   endtask

   task automatic write_bucket(input logic [INDEX_W-1:0] index,
                               input logic [FIRST_W-1:0] first,
                               input logic [COUNT_W-1:0] count);
      gal_req_type item;
      item = noise_item();
      item.action = ACT_WR_BUCKET;
      item.table_index = index;
      item.bucket_first = first;
      item.bucket_count = count;
      send_item(item);
   endtask

   task automatic write_glyph(input logic [INDEX_W-1:0] index,
                              input logic [CODE_W-1:0] code,
                              input logic [OFFSET_W-1:0] offset);
      gal_req_type item;
      item = noise_item();
      item.action = ACT_WR_GLYPH;
      item.table_index = index;
      item.char_code = code;
      item.entry_offset = offset;
      send_item(item);
   endtask

   // Waits until every lookup has answered and the core has gone quiet.
   task automatic settle();
      start <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_config(input logic mode, input logic [31:0] base);
      csr_we <= 1'b1;
      csr_index <= CSR_LOOKUP_MODE;
      csr_wdata <= {31'b0, mode};
      @(posedge clock);
      csr_index <= CSR_DATA_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_q.lookup_mode = mode;
      cfg_q.data_base = base;
      n_settings++;
   endtask

   task automatic test_directed_cases();
      bit sent;
      program_config(LOOKUP_DIRECT, 32'h0000_0000);
      write_direct(12'd0, 32'hABCD_0000);
      write_direct(12'd255, 32'h1234_FFFE);
      write_direct(12'd7, 32'h0000_FFFF);
      write_direct(12'd256, 32'h0000_1111);
      write_direct(12'd4095, 32'hFFFF_FFFF);
      send_lookup(16'h0000, sent);
      send_lookup(16'h00FF, sent);
      send_lookup(16'h0007, sent);
      send_lookup(16'h0100, sent);
      send_lookup(16'hFFFF, sent);
      settle();
      program_config(LOOKUP_DIRECT, 32'hFFFF_FFF0);
      send_lookup(16'h00FF, sent);
      settle();
      program_config(LOOKUP_BUCKETED, 32'h8000_0000);
      write_bucket(12'd0, 12'd5, 13'd0);
      write_bucket(12'd255, 12'd4094, 13'd8191);
      write_bucket(12'd256, 12'd0, 13'd1);
      write_glyph(12'd0, 16'h0042, 32'h0000_0009);
      write_glyph(12'd4094, 16'hFFFF, 32'hFFFF_FFFF);
      write_glyph(12'd4095, 16'hFF01, 32'h0000_0005);
      send_lookup(16'h0042, sent);
      send_lookup(16'hFFFF, sent);
      send_lookup(16'hFF01, sent);
      send_lookup(16'hFF77, sent);
      write_bucket(12'd1, 12'd10, 13'd4);
      write_glyph(12'd10, 16'h0100, 32'h0000_0000);
      write_glyph(12'd11, 16'h0000, 32'h0000_0000);
      send_lookup(16'h0100, sent);
      send_lookup(16'h0155, sent);
   endtask

   task automatic test_random_direct_table();
      logic [31:0]       base;
      logic [31:0]       rnd;
      logic [CODE_W-1:0] code;
      int                pick;
      bit                sent;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: base = 32'h0000_0000;
            1: base = 32'hFFFF_FFFF;
            default: base = $urandom;
         endcase
         settle();
         program_config(LOOKUP_DIRECT, base);
         repeat (60) begin
            pick = $urandom_range(0, 99);
            rnd = $urandom;
            if (pick < 65) begin
               code = ($urandom_range(0, 4) == 0) ? rnd[15:0] : {8'h00, rnd[7:0]};
               send_lookup(code, sent);
               if (!sent) write_direct({4'h0, code[7:0]}, direct_offset());
            end else if (pick < 90) begin
               write_direct({4'h0, rnd[7:0]}, direct_offset());
            end else begin
               write_direct(INDEX_W'($urandom_range(256, 4095)), $urandom);
            end
         end
      end
   endtask

   task automatic test_random_bucket_search();
      logic [7:0]        bucket_id;
      logic [CODE_W-1:0] code;
      logic [31:0]       rnd;
      logic [31:0]       offset;
      logic [CODE_W-1:0] bucket_codes [$];
      int                first;
      int                count;
      int                n;
      int                term_at;
      int                shape;
      int                pick;
      bit                sent;
      for (int b = 0; b < 30; b++) begin
         if (b % 10 == 0) begin
            settle();
            case (b / 10)
               0: program_config(LOOKUP_BUCKETED, 32'h0000_0000);
               1: program_config(LOOKUP_BUCKETED, $urandom);
               default: program_config(LOOKUP_BUCKETED, 32'hFFFF_FF00);
            endcase
         end
         bucket_id = 8'($urandom_range(0, 255));
         shape = $urandom_range(0, 99);
         term_at = -1;
         if (shape < 8) begin
            first = $urandom_range(0, 4095);
            count = 0;
            n = 0;
         end else if (shape < 14) begin
            first = $urandom_range(4088, 4095);
            count = $urandom_range(4096, 8191);
            n = GLYPH_ENTRIES - first;
         end else if (shape < 20) begin
            first = $urandom_range(0, 4000);
            count = $urandom_range(4096, 8191);
            term_at = $urandom_range(1, 5);
            n = term_at + 1;
         end else begin
            first = $urandom_range(0, 4095);
            count = $urandom_range(1, 8);
            n = (first + count > GLYPH_ENTRIES) ? GLYPH_ENTRIES - first : count;
            if ($urandom_range(0, 3) == 0) term_at = $urandom_range(0, n - 1);
         end
         write_bucket({4'h0, bucket_id}, FIRST_W'(first), COUNT_W'(count));
         bucket_codes.delete();
         for (int j = 0; j < n; j++) begin
            if (j == term_at) begin
               write_glyph(INDEX_W'(first + j), 16'h0000, 32'h0000_0000);
            end else begin
               rnd = $urandom;
               offset = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
               code = ($urandom_range(0, 7) == 0) ? rnd[15:0] : {bucket_id, rnd[7:0]};
               write_glyph(INDEX_W'(first + j), code, offset);
               bucket_codes.push_back(code);
               if (known_codes.size() < 512) known_codes.push_back(code);
            end
         end
         repeat ($urandom_range(2, 6)) begin
            pick = $urandom_range(0, 99);
            rnd = $urandom;
            if (pick < 60 && bucket_codes.size() > 0)
               code = bucket_codes[$urandom_range(0, bucket_codes.size() - 1)];
            else if (pick < 85)
               code = {bucket_id, rnd[7:0]};
            else if (known_codes.size() > 0)
               code = known_codes[$urandom_range(0, known_codes.size() - 1)];
            else
               code = rnd[15:0];
            send_lookup(code, sent);
         end
         if ($urandom_range(0, 9) == 0)
            write_glyph(INDEX_W'($urandom), CODE_W'($urandom), $urandom);
         if ($urandom_range(0, 9) == 0)
            write_bucket(INDEX_W'($urandom_range(256, 4095)), FIRST_W'($urandom),
                         COUNT_W'($urandom));
      end
   endtask

   task automatic test_mode_switch();
      logic [CODE_W-1:0] code;
      logic [31:0]       rnd;
      logic              mode;
      bit                sent;
      for (int p = 0; p < 4; p++) begin
         mode = (p % 2 == 0) ? LOOKUP_DIRECT : LOOKUP_BUCKETED;
         settle();
         case (p)
            0: program_config(mode, 32'h0000_1000);
            1: program_config(mode, 32'hFFFF_FFFF);
            2: program_config(mode, $urandom);
            default: program_config(mode, 32'h0000_0000);
         endcase
         repeat (15) begin
            rnd = $urandom;
            if (mode == LOOKUP_DIRECT) begin
               code = ($urandom_range(0, 3) == 0) ? rnd[15:0] : {8'h00, rnd[7:0]};
               send_lookup(code, sent);
               if (!sent) write_direct({4'h0, code[7:0]}, direct_offset());
            end else begin
               if (known_codes.size() > 0 && $urandom_range(0, 3) != 0)
                  code = known_codes[$urandom_range(0, known_codes.size() - 1)];
               else
                  code = rnd[15:0];
               send_lookup(code, sent);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      gal_rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_lookups.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual found=%0b address=%08h",
                     $time, rsp_data.found, rsp_data.glyph_address);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.found !== want.found) begin
               mismatches++;
               $display("%0t: found mismatch, expected %0b, actual %0b",
                        $time, want.found, rsp_data.found);
            end
            if (rsp_data.glyph_address !== want.glyph_address) begin
               mismatches++;
               $display("%0t: glyph_address mismatch, expected %08h, actual %08h",
                        $time, want.glyph_address, rsp_data.glyph_address);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
         $display("tb_glyph_address_lookup_core failed");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      n_lookups = 0;
      n_hits = 0;
      n_writes = 0;
      n_settings = 0;
      burst_left = 0;
      stall_cycles = 0;
      cfg_q = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_direct_table();
      test_random_bucket_search();
      test_mode_switch();
      settle();
      $display("Covered %0d lookups (%0d hits, %0d misses) and %0d table writes.",
               n_lookups, n_hits, n_lookups - n_hits, n_writes);
      $display("Both lookup modes were run over %0d register settings.", n_settings);
      if (mismatches == 0 && pending_lookups.size() == 0) begin
         $display("tb_glyph_address_lookup_core passed");
      end else begin
         $display("tb_glyph_address_lookup_core failed");
      end
      $finish;
   end

endmodule
